// ===== rtl/twf_pkg.sv =====
// Shared types and codes for the readout word filter.
`default_nettype none
package twf_pkg;

    localparam int WORD_W = 16;
    localparam int CHAN_W = 5;
    localparam int FINE_W = 10;
    localparam int TIME_W = 17;
    localparam int SEP_W  = 10;
    localparam logic [SEP_W-1:0] SEP_RESET = 10'd100;

    typedef enum logic [1:0] {
        REQ_HEADER = 2'd0,
        REQ_BLOCK  = 2'd1,
        REQ_DIRECT = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_GOOD      = 4'd0,
        ST_END       = 4'd1,
        ST_ORDER     = 4'd2,
        ST_TRIPLE    = 4'd3,
        ST_CLOSE     = 4'd4,
        ST_LAST      = 4'd5,
        ST_MARKER    = 4'd6,
        ST_HEADER    = 4'd7,
        ST_NO_HEADER = 4'd8,
        ST_HALF      = 4'd9
    } status_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        req_t              op;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              end_mark;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        status_t           status;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] hit_time;
        logic              edge_rec;
        logic              edge_mode;
        logic [1:0]        shift_val;
        logic              single_mode;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/twf_fifo.sv =====
// Small first-in first-out queue with full and empty flags.
`default_nettype none
module twf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/twf_front.sv =====
// Front end: accept input words, classify them and drop unused selectors.
`default_nettype none
module twf_front
    import twf_pkg::*;
(
    input  wire logic              push,
    input  wire logic              cmd_full,
    input  wire logic [1:0]        req_type,
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [WORD_W-1:0] next_word,
    input  wire logic              last_in_block,
    output logic                   cmd_push,
    output cmd_t                   cmd
);
    req_t op;

    assign op = req_t'(req_type);

    always_comb
    begin
        cmd.op       = op;
        cmd.word     = word;
        cmd.last     = last_in_block;
        // two zero words in a row end the data, unless this is the last word
        cmd.end_mark = (word == '0) && (next_word == '0) && !last_in_block;
        cmd_push     = push && !cmd_full && (op != REQ_UNUSED);
    end

endmodule
`default_nettype wire

// ===== rtl/twf_back.sv =====
// Back end: header registers, channel history filter and double-word pairing.
`default_nettype none
module twf_back
    import twf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [SEP_W-1:0] cfg_wr_data,
    input  wire logic             cmd_valid,
    input  wire cmd_t             cmd,
    output logic                  cmd_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output res_t                  res
);
    logic [SEP_W-1:0]  sep_reg;
    logic              edge_reg, edge_next;
    logic [1:0]        shift_reg, shift_next;
    logic              single_reg, single_next;
    logic [CHAN_W-1:0] prev_chan_reg, prev_chan_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [CHAN_W-1:0] prev2_chan_reg, prev2_chan_next;
    logic              prev2_valid_reg, prev2_valid_next;
    logic [FINE_W-1:0] prev_time_reg, prev_time_next;
    logic              half_pend_reg, half_pend_next;
    logic [WORD_W-1:0] half_time_reg, half_time_next;
    logic [CHAN_W-1:0] half_chan_reg, half_chan_next;

    logic [WORD_W-1:0] w;
    logic [CHAN_W-1:0] chan;
    logic [FINE_W-1:0] fine;
    logic [WORD_W-1:0] byte_t;
    logic [FINE_W-1:0] abs_diff;
    logic              too_close;
    logic              fire;

    assign fire     = cmd_valid && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    assign w      = cmd.word;
    assign chan   = w[14:10];
    assign fine   = edge_reg ? {1'b0, w[8:0]} : w[9:0];
    assign byte_t = w[8] ? {w[7:0], 8'h00} : {8'h00, w[7:0]};
    assign abs_diff = (fine >= prev_time_reg) ? (fine - prev_time_reg)
                                               : (prev_time_reg - fine);
    assign too_close = (abs_diff < sep_reg);

    always_comb
    begin
        edge_next        = edge_reg;
        shift_next       = shift_reg;
        single_next      = single_reg;
        prev_chan_next   = prev_chan_reg;
        prev_valid_next  = prev_valid_reg;
        prev2_chan_next  = prev2_chan_reg;
        prev2_valid_next = prev2_valid_reg;
        prev_time_next   = prev_time_reg;
        half_pend_next   = half_pend_reg;
        half_time_next   = half_time_reg;
        half_chan_next   = half_chan_reg;
        res.status       = ST_GOOD;
        res.channel      = chan;
        res.hit_time     = '0;
        res.edge_rec     = 1'b0;

        case (cmd.op)
            REQ_HEADER:
            begin
                edge_next   = w[10];
                shift_next  = w[9:8];
                single_next = ~w[14];
                res.status  = w[15] ? ST_HEADER : ST_NO_HEADER;
                res.channel = '0;
            end
            REQ_BLOCK:
            begin
                res.hit_time = TIME_W'(fine);
                if (cmd.end_mark)
                begin
                    res.status = ST_END;
                end
                else if (prev_valid_reg && chan < prev_chan_reg)
                begin
                    res.status = ST_ORDER;
                end
                else if (prev_valid_reg && chan == prev_chan_reg && prev2_valid_reg
                         && prev2_chan_reg == prev_chan_reg)
                begin
                    res.status = ST_TRIPLE;
                end
                else if (prev_valid_reg && chan == prev_chan_reg && too_close)
                begin
                    res.status = ST_CLOSE;
                end
                else
                begin
                    // record the hit, then drop tracking on the last word
                    prev_time_next   = fine;
                    prev2_chan_next  = prev_chan_reg;
                    prev2_valid_next = prev_valid_reg;
                    prev_chan_next   = chan;
                    prev_valid_next  = 1'b1;
                    res.status       = cmd.last ? ST_LAST : ST_GOOD;
                end
                if (res.status != ST_GOOD)
                begin
                    prev_chan_next   = '0;
                    prev_valid_next  = 1'b0;
                    prev2_chan_next  = '0;
                    prev2_valid_next = 1'b0;
                end
            end
            REQ_DIRECT:
            begin
                if (w[15])
                begin
                    res.status     = ST_MARKER;
                    half_pend_next = 1'b0;
                end
                else if (single_reg)
                begin
                    res.hit_time = TIME_W'(fine);
                    res.edge_rec = w[9];
                end
                else if (!half_pend_reg)
                begin
                    res.status     = ST_HALF;
                    res.hit_time   = TIME_W'(byte_t);
                    res.edge_rec   = w[9];
                    half_time_next = byte_t;
                    half_chan_next = chan;
                    half_pend_next = 1'b1;
                end
                else
                begin
                    res.hit_time   = TIME_W'(half_time_reg) + TIME_W'(byte_t);
                    res.edge_rec   = w[9];
                    res.channel    = half_chan_reg;
                    half_pend_next = 1'b0;
                end
            end
            default:
            begin
                res.status = ST_GOOD;
            end
        endcase

        res.edge_mode   = edge_next;
        res.shift_val   = shift_next;
        res.single_mode = single_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg         <= SEP_RESET;
            edge_reg        <= 1'b0;
            shift_reg       <= '0;
            single_reg      <= 1'b0;
            prev_chan_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            prev2_chan_reg  <= '0;
            prev2_valid_reg <= 1'b0;
            prev_time_reg   <= '0;
            half_pend_reg   <= 1'b0;
            half_time_reg   <= '0;
            half_chan_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sep_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                edge_reg        <= edge_next;
                shift_reg       <= shift_next;
                single_reg      <= single_next;
                prev_chan_reg   <= prev_chan_next;
                prev_valid_reg  <= prev_valid_next;
                prev2_chan_reg  <= prev2_chan_next;
                prev2_valid_reg <= prev2_valid_next;
                prev_time_reg   <= prev_time_next;
                half_pend_reg   <= half_pend_next;
                half_time_reg   <= half_time_next;
                half_chan_reg   <= half_chan_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tdc_readout_word_filter.sv =====
// Top level of the readout word filter: front end, command queue, back end, result queue.
//
//  channel   handshake          payload
//  -------   ---------          -------------------------------------------------
//  input     push / full        req_type, word, next_word, last_in_block
//  result    empty / pop        status, channel, hit_time, edge_rec, edge_mode,
//                               shift_val, single_mode
//  config    cfg_wr_en          cfg_wr_data (min_separation, 10 bits)
//
//  One word per cycle sustained while neither queue is full. An accepted word is
//  written into the command queue, passes through the back end's combinational
//  filter into the result queue and is then shown on the result ports, where
//  pop can take it.
//  A word with the unused selector is accepted and dropped with no result.
//  Reset clears the queues, the header registers and the channel history, and
//  loads min_separation with 100.
//  When pop stalls, the result queue fills, then the back end holds, then the
//  command queue fills and full rises; each side stalls on its own.
`default_nettype none
module tdc_readout_word_filter
    import twf_pkg::*;
#(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [1:0]        req_type,
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [WORD_W-1:0] next_word,
    input  wire logic              last_in_block,
    output logic                   empty,
    input  wire logic              pop,
    output logic [3:0]             status,
    output logic [CHAN_W-1:0]      channel,
    output logic [TIME_W-1:0]      hit_time,
    output logic                   edge_rec,
    output logic                   edge_mode,
    output logic [1:0]             shift_val,
    output logic                   single_mode,
    input  wire logic              cfg_wr_en,
    input  wire logic [SEP_W-1:0]  cfg_wr_data
);
    cmd_t cmd_in, cmd_out;
    logic cmd_push, cmd_pop, cmd_full, cmd_empty;
    res_t res_in, res_out;
    logic res_push, res_full;

    // Accept whenever the command queue has room; classify on the way in.
    assign full = cmd_full;

    twf_front u_front (
        .push          (push),
        .cmd_full      (cmd_full),
        .req_type      (req_type),
        .word          (word),
        .next_word     (next_word),
        .last_in_block (last_in_block),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in)
    );

    twf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // Advance one command per cycle while the result queue has room.
    twf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (!cmd_empty),
        .cmd         (cmd_out),
        .cmd_pop     (cmd_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_in)
    );

    twf_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    // Present the oldest result transaction.
    assign status      = res_out.status;
    assign channel     = res_out.channel;
    assign hit_time    = res_out.hit_time;
    assign edge_rec    = res_out.edge_rec;
    assign edge_mode   = res_out.edge_mode;
    assign shift_val   = res_out.shift_val;
    assign single_mode = res_out.single_mode;

endmodule
`default_nettype wire

// ===== rtl/twf_checker.sv =====
// Port-level checks on the readout word filter, bound to the top level.
`default_nettype none
module twf_checker
    import twf_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [3:0]        status,
    input wire logic [CHAN_W-1:0] channel,
    input wire logic [TIME_W-1:0] hit_time,
    input wire logic              edge_rec
);
    // Only a completed pair can carry time above 16 bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_GOOD) |-> !hit_time[TIME_W-1])
    else $error("wide hit time on a result that is not a paired hit");

    // Header results carry no channel, time or edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_HEADER || status == ST_NO_HEADER))
        |-> (channel == '0 && hit_time == '0 && !edge_rec))
    else $error("header result with hit fields set");

    // Block results with a non-good status keep the fine time range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_ORDER || status == ST_TRIPLE || status == ST_CLOSE
                    || status == ST_END || status == ST_LAST))
        |-> (hit_time < TIME_W'(1024) && !edge_rec))
    else $error("block result time out of range");

    // A waiting result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(channel)
                              && $stable(hit_time)))
    else $error("result changed while stalled");

endmodule

bind tdc_readout_word_filter twf_checker u_twf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .channel  (channel),
    .hit_time (hit_time),
    .edge_rec (edge_rec)
);
`default_nettype wire
